[hw/rtl/hss_pkg.sv]
// shared types, constants and coil sequence for the half-step stepper unit
`default_nettype none

package hss_pkg;

   localparam int STEP_COUNT_WIDTH = 24;
   localparam int MARK_COUNT_WIDTH = 8;
   localparam int TICK_WIDTH       = 16;
   localparam int DEBOUNCE_WIDTH   = 10;
   localparam int PHASE_WIDTH      = 3;
   localparam int COIL_WIDTH       = 4;
   localparam int CMD_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;

   localparam logic [TICK_WIDTH-1:0]     TICKS_PER_STEP_RESET = TICK_WIDTH'(1);
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET       = DEBOUNCE_WIDTH'(100);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TICKS_PER_STEP = 2'd0,
      CSR_DEBOUNCE_STEPS = 2'd1,
      CSR_UNUSED_2       = 2'd2,
      CSR_UNUSED_3       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COIL_WIDTH-1:0]       travel_coils;
      logic [COIL_WIDTH-1:0]       hoist_coils;
      logic                        moving;
      logic [MARK_COUNT_WIDTH-1:0] marks_counted;
      logic [STEP_COUNT_WIDTH-1:0] steps_left;
   } rsp_type;

   // 8-phase half-step sequence, bit0 = IN1
   function automatic logic [COIL_WIDTH-1:0] coil_pattern(input logic [PHASE_WIDTH-1:0] phase);
      logic [COIL_WIDTH-1:0] pat;
      begin
         case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
         endcase
         return pat;
      end
   endfunction

endpackage

`default_nettype wire

[hw/rtl/hss_core.sv]
// motion state, prescaler, phase sequencer and mark counter
`default_nettype none

module hss_core
   import hss_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  wire logic                        req_fire,
   input  wire logic [CMD_WIDTH-1:0]        req_command,
   input  wire logic                        req_mark_present,
   input  wire logic                        req_axis_is_travel,
   input  wire logic                        req_direction_positive,
   input  wire logic [STEP_COUNT_WIDTH-1:0] req_step_count,
   input  wire logic [MARK_COUNT_WIDTH-1:0] req_target_marks,
   output rsp_type                          rsp_next
);

   localparam logic [MARK_COUNT_WIDTH-1:0] MARK_MAX = {MARK_COUNT_WIDTH{1'b1}};

   logic [TICK_WIDTH-1:0]       ticks_per_step_ff;
   logic [DEBOUNCE_WIDTH-1:0]   debounce_steps_ff;

   logic [PHASE_WIDTH-1:0]      phase_ff, phase_in;
   logic [TICK_WIDTH-1:0]       tick_ff, tick_in;
   logic [STEP_COUNT_WIDTH-1:0] steps_ff, steps_in;
   logic                        active_ff, active_in;
   logic                        travel_ff, travel_in;
   logic                        forward_ff, forward_in;
   logic [MARK_COUNT_WIDTH-1:0] mark_count_ff, mark_count_in;
   logic [MARK_COUNT_WIDTH-1:0] mark_target_ff, mark_target_in;
   logic                        last_mark_ff, last_mark_in;
   logic [DEBOUNCE_WIDTH-1:0]   since_mark_ff, since_mark_in;
   logic [COIL_WIDTH-1:0]       travel_pat_ff, travel_pat_in;
   logic [COIL_WIDTH-1:0]       hoist_pat_ff, hoist_pat_in;

   logic [TICK_WIDTH-1:0]       tick_inc;
   logic [PHASE_WIDTH-1:0]      phase_step;
   cmd_type                     cmd;

   assign cmd = cmd_type'(req_command);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_step_ff <= TICKS_PER_STEP_RESET;
         debounce_steps_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_STEP: ticks_per_step_ff <= csr_wdata;
            CSR_DEBOUNCE_STEPS: debounce_steps_ff <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      steps_in       = steps_ff;
      active_in      = active_ff;
      travel_in      = travel_ff;
      forward_in     = forward_ff;
      mark_count_in  = mark_count_ff;
      mark_target_in = mark_target_ff;
      last_mark_in   = last_mark_ff;
      since_mark_in  = since_mark_ff;
      travel_pat_in  = travel_pat_ff;
      hoist_pat_in   = hoist_pat_ff;
      tick_inc       = tick_ff + TICK_WIDTH'(1);
      phase_step     = forward_ff ? PHASE_WIDTH'(1) : PHASE_WIDTH'(7);

      case (cmd)
         CMD_TICK: begin
            if (active_ff && (steps_ff != '0)) begin
               if (tick_inc >= ticks_per_step_ff) begin
                  tick_in  = '0;
                  phase_in = phase_ff + phase_step;
                  if (travel_ff) begin
                     travel_pat_in = coil_pattern(phase_in);
                     if (since_mark_ff < debounce_steps_ff) begin
                        since_mark_in = since_mark_ff + DEBOUNCE_WIDTH'(1);
                     end
                     if (req_mark_present && !last_mark_ff &&
                         (since_mark_in >= debounce_steps_ff)) begin
                        if (mark_count_ff != MARK_MAX) begin
                           mark_count_in = mark_count_ff + MARK_COUNT_WIDTH'(1);
                        end
                        since_mark_in = '0;
                        if ((mark_target_ff != '0) && (mark_count_in >= mark_target_ff)) begin
                           active_in = 1'b0;
                        end
                     end
                     last_mark_in = req_mark_present;
                  end else begin
                     hoist_pat_in = coil_pattern(phase_in);
                  end
                  steps_in = steps_ff - STEP_COUNT_WIDTH'(1);
                  if (steps_in == '0) begin
                     active_in = 1'b0;
                  end
               end else begin
                  tick_in = tick_inc;
               end
            end
         end
         CMD_START: begin
            travel_in      = req_axis_is_travel;
            forward_in     = req_direction_positive;
            steps_in       = req_step_count;
            mark_count_in  = '0;
            mark_target_in = req_target_marks;
            tick_in        = '0;
            if (req_axis_is_travel) begin
               last_mark_in  = req_mark_present;
               since_mark_in = debounce_steps_ff;
            end
            active_in = (req_step_count != '0);
         end
         CMD_STOP: begin
            active_in = 1'b0;
            steps_in  = '0;
         end
         default: ;
      endcase

      rsp_next.travel_coils  = travel_pat_in;
      rsp_next.hoist_coils   = hoist_pat_in;
      rsp_next.moving        = active_in;
      rsp_next.marks_counted = mark_count_in;
      rsp_next.steps_left    = steps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         tick_ff        <= '0;
         steps_ff       <= '0;
         active_ff      <= 1'b0;
         travel_ff      <= 1'b1;
         forward_ff     <= 1'b1;
         mark_count_ff  <= '0;
         mark_target_ff <= '0;
         last_mark_ff   <= 1'b0;
         since_mark_ff  <= '0;
         travel_pat_ff  <= '0;
         hoist_pat_ff   <= '0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         tick_ff        <= tick_in;
         steps_ff       <= steps_in;
         active_ff      <= active_in;
         travel_ff      <= travel_in;
         forward_ff     <= forward_in;
         mark_count_ff  <= mark_count_in;
         mark_target_ff <= mark_target_in;
         last_mark_ff   <= last_mark_in;
         since_mark_ff  <= since_mark_in;
         travel_pat_ff  <= travel_pat_in;
         hoist_pat_ff   <= hoist_pat_in;
      end
   end

   a_active_has_budget: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_ff != '0))
      else $error("move active with empty step budget");

   a_target_stops: assert property (@(posedge clock) disable iff (reset)
      ((mark_target_ff != '0) && (mark_count_ff >= mark_target_ff)) |-> !active_ff)
      else $error("move still active after mark target reached");

   a_phase_single_step: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != $past(phase_ff)) |->
         ((phase_ff == $past(phase_ff) + PHASE_WIDTH'(1)) ||
          (phase_ff == $past(phase_ff) - PHASE_WIDTH'(1))))
      else $error("phase moved by more than one half-step");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd == CMD_TICK) && !active_ff) |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("tick while idle changed the sequencer");

endmodule

`default_nettype wire

[hw/rtl/hss_rsp_buf.sv]
// two-entry result buffer: output register plus skid register
`default_nettype none

module hss_rsp_buf
   import hss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         push_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop        = main_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!main_valid_ff) begin
            main_valid_ff <= push;
         end else if (pop) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               main_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || (pop && !skid_valid_ff)) begin
         main_ff <= push_data;
      end else if (pop) begin
         main_ff <= skid_ff;
      end
      if (main_valid_ff && !pop && push) begin
         skid_ff <= push_data;
      end
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid beat held without an output beat");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("beat pushed into a full buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to output register");

endmodule

`default_nettype wire

[hw/rtl/half_step_stepper_with_mark_stop_unit.sv]
// top level of the two-axis half-step stepper sequencer with mark stop
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   command and move fields
//   rsp_      out         rsp_valid/rsp_ready   coil patterns and status
//   csr_      in          csr_valid/csr_ready   csr_index, csr_wdata
//
// one result beat per request beat, registered in the output buffer before rsp_valid
// a request beat can be taken every cycle while the skid entry is empty; the state update is a single pass
// a two-entry output buffer keeps req_ready high through one stalled rsp beat
// synchronous active-high reset; coils off, travel axis forward, idle
// csr writes are always ready and take effect on the next cycle
`default_nettype none

module half_step_stepper_with_mark_stop_unit
   import hss_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [CMD_WIDTH-1:0]        req_command,
   input  wire logic                        req_mark_present,
   input  wire logic                        req_axis_is_travel,
   input  wire logic                        req_direction_positive,
   input  wire logic [STEP_COUNT_WIDTH-1:0] req_step_count,
   input  wire logic [MARK_COUNT_WIDTH-1:0] req_target_marks,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [COIL_WIDTH-1:0]            rsp_travel_coils,
   output logic [COIL_WIDTH-1:0]            rsp_hoist_coils,
   output logic                             rsp_moving,
   output logic [MARK_COUNT_WIDTH-1:0]      rsp_marks_counted,
   output logic [STEP_COUNT_WIDTH-1:0]      rsp_steps_left,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic    req_fire;
   rsp_type rsp_next;
   rsp_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   hss_core u_core (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_fire               (req_fire),
      .req_command            (req_command),
      .req_mark_present       (req_mark_present),
      .req_axis_is_travel     (req_axis_is_travel),
      .req_direction_positive (req_direction_positive),
      .req_step_count         (req_step_count),
      .req_target_marks       (req_target_marks),
      .rsp_next               (rsp_next)
   );

   hss_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (rsp_next),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_travel_coils  = rsp_data.travel_coils;
   assign rsp_hoist_coils   = rsp_data.hoist_coils;
   assign rsp_moving        = rsp_data.moving;
   assign rsp_marks_counted = rsp_data.marks_counted;
   assign rsp_steps_left    = rsp_data.steps_left;

endmodule

`default_nettype wire
